### hdl/bale_pkg.sv
// shared types and codes for the bounded array list engine
package bale_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W = 9;
  localparam int unsigned FPOS_W = 8;

  typedef enum logic [2:0] {
    CMD_APPEND       = 3'd0,
    CMD_INSERT       = 3'd1,
    CMD_SET          = 3'd2,
    CMD_GET          = 3'd3,
    CMD_FIND         = 3'd4,
    CMD_REMOVE_AT    = 3'd5,
    CMD_REMOVE_VALUE = 3'd6,
    CMD_CLEAR        = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_INDEX = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  // per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;    // cells below the tail take their upper neighbor
    logic wr_last;  // tail cell (len-1) takes last_data
    logic wr_end;   // cell just past the tail (len) takes end_data
  } cell_ctl_t;

endpackage

### hdl/bale_cell.sv
// one storage cell of the list chain
module bale_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned LW  = 9
) (
  input  logic                          clk_i,
  input  bale_pkg::cell_ctl_t           ctl_i,
  input  logic [LW-1:0]                 len_i,
  input  logic [bale_pkg::WORD_W-1:0]   next_i,
  input  logic [bale_pkg::WORD_W-1:0]   last_data_i,
  input  logic [bale_pkg::WORD_W-1:0]   end_data_i,
  output logic [bale_pkg::WORD_W-1:0]   word_o
);

  localparam logic [LW-1:0] IDX_L  = LW'(IDX);
  localparam logic [LW-1:0] IDX_P1 = LW'(IDX + 1);

  logic [bale_pkg::WORD_W-1:0] word_q;
  logic is_end;
  logic is_last;
  logic below_last;

  assign is_end     = (len_i == IDX_L);
  assign is_last    = (len_i == IDX_P1);
  assign below_last = (IDX_P1 < len_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_end && is_end) begin
      word_q <= end_data_i;
    end else if (ctl_i.wr_last && is_last) begin
      word_q <= last_data_i;
    end else if (ctl_i.shift && below_last) begin
      word_q <= next_i;
    end
  end

  assign word_o = word_q;

endmodule

### hdl/bounded_array_list_engine.sv
// top level: command sequencer, result register and the chain of list cells
//
// The list lives in a chain of CAPACITY cells; entry i sits in cell i. Append, clear and
// commands rejected with a bad index or full status go from acceptance straight to the
// finish state, which registers their result. Insert (below the end), set, get, find,
// remove_at and remove_value first rotate the live part of the chain once through cell 0,
// one entry per cycle, editing the stream as it is written back at the tail, and then
// register their result in the finish state (find and remove_value on an empty list take
// the short path). One command is worked on at a time; the result register lets the next
// command be accepted while the previous result is still waiting to be taken, and a
// finished command waits in the finish state until that register is free, so a long
// output stall holds up the command behind it.
module bounded_array_list_engine #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          command_i,
  input  logic [8:0]          position_i,
  input  logic signed [31:0]  word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  read_word_o,
  output logic                found_o,
  output logic [7:0]          found_position_o,
  output logic [8:0]          list_length_o
);

  localparam int unsigned LW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (LW > bale_pkg::POS_W) ? LW : bale_pkg::POS_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  bale_pkg::state_e  state_q, state_d;
  bale_pkg::cmd_e    cmd_q, cmd_in;
  bale_pkg::status_e status_q, status_in;
  bale_pkg::status_e out_status_q;

  logic [LW-1:0]                 count_q, count_d;
  logic [LW-1:0]                 cnt_q;
  logic [LW-1:0]                 i_q;
  logic [bale_pkg::POS_W-1:0]    pos_q;
  logic [bale_pkg::WORD_W-1:0]   word_q;
  logic                          app_q;
  logic [bale_pkg::WORD_W-1:0]   rd_q;
  logic                          found_q;
  logic [bale_pkg::FPOS_W-1:0]   fpos_q;

  logic                          out_valid_q;
  logic [bale_pkg::WORD_W-1:0]   out_rd_q;
  logic                          out_found_q;
  logic [bale_pkg::FPOS_W-1:0]   out_fpos_q;
  logic [bale_pkg::POS_W-1:0]    out_len_q;

  logic accept;
  logic out_load;
  logic need_scan;
  logic app_in;
  logic full;
  logic hit;
  logic match;
  logic grow;
  logic shrink;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] i_ext;
  logic [CMPW-1:0] pos_q_ext;
  logic [CMPW-1:0] len_ext;

  bale_pkg::cell_ctl_t          cell_ctl;
  logic [bale_pkg::WORD_W-1:0]  last_data;
  logic [bale_pkg::WORD_W-1:0]  end_data;
  logic [bale_pkg::WORD_W-1:0]  tap;
  logic [bale_pkg::WORD_W-1:0]  cell_word [CAPACITY];

  // chain of cells, cell 0 is the read tap
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [bale_pkg::WORD_W-1:0] next_word;
    if (k == CAPACITY - 1) begin : g_top
      assign next_word = cell_word[k];
    end else begin : g_mid
      assign next_word = cell_word[k + 1];
    end
    bale_cell #(
      .IDX (k),
      .LW  (LW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .len_i       (count_q),
      .next_i      (next_word),
      .last_data_i (last_data),
      .end_data_i  (end_data),
      .word_o      (cell_word[k])
    );
  end

  assign tap = cell_word[0];

  // command decode at acceptance
  assign cmd_in  = bale_pkg::cmd_e'(command_i);
  assign pos_ext = CMPW'(position_i);
  assign cnt_ext = CMPW'(count_q);
  assign full    = (count_q == CAP_L);
  assign accept  = in_valid_i && !in_stall_o;

  always_comb begin
    status_in = bale_pkg::STS_OK;
    need_scan = 1'b0;
    app_in    = 1'b0;
    case (cmd_in)
      bale_pkg::CMD_APPEND: begin
        if (full) begin
          status_in = bale_pkg::STS_FULL;
        end else begin
          app_in = 1'b1;
        end
      end
      bale_pkg::CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_in = bale_pkg::STS_BAD_INDEX;
        end else if (full) begin
          status_in = bale_pkg::STS_FULL;
        end else if (pos_ext == cnt_ext) begin
          app_in = 1'b1;
        end else begin
          need_scan = 1'b1;
        end
      end
      bale_pkg::CMD_SET, bale_pkg::CMD_GET, bale_pkg::CMD_REMOVE_AT: begin
        if (pos_ext >= cnt_ext) begin
          status_in = bale_pkg::STS_BAD_INDEX;
        end else begin
          need_scan = 1'b1;
        end
      end
      bale_pkg::CMD_FIND, bale_pkg::CMD_REMOVE_VALUE: begin
        need_scan = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_load  = !out_valid_q || !out_stall_i;
  assign i_ext     = CMPW'(i_q);
  assign pos_q_ext = CMPW'(pos_q);
  assign hit       = (i_ext == pos_q_ext);
  assign match     = (tap == word_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bale_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (need_scan && (count_q != '0)) ? bale_pkg::ST_SCAN : bale_pkg::ST_FIN;
        end
      end
      bale_pkg::ST_SCAN: begin
        if (i_q == cnt_q - LW'(1)) begin
          state_d = bale_pkg::ST_FIN;
        end
      end
      bale_pkg::ST_FIN: begin
        if (out_load) begin
          state_d = bale_pkg::ST_IDLE;
        end
      end
      default: state_d = bale_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and cell control
  always_comb begin
    in_stall_o = (state_q != bale_pkg::ST_IDLE);
    cell_ctl   = '0;
    last_data  = tap;
    end_data   = word_q;
    grow       = 1'b0;
    shrink     = 1'b0;
    case (state_q)
      bale_pkg::ST_SCAN: begin
        cell_ctl.shift = 1'b1;
        case (cmd_q)
          bale_pkg::CMD_INSERT: begin
            // new word goes to the tail, the tapped entry right behind it
            cell_ctl.wr_last = 1'b1;
            cell_ctl.wr_end  = hit;
            last_data        = hit ? word_q : tap;
            end_data         = tap;
            grow             = hit;
          end
          bale_pkg::CMD_SET: begin
            cell_ctl.wr_last = 1'b1;
            last_data        = hit ? word_q : tap;
          end
          bale_pkg::CMD_REMOVE_AT: begin
            cell_ctl.wr_last = !hit;
            shrink           = hit;
          end
          bale_pkg::CMD_REMOVE_VALUE: begin
            cell_ctl.wr_last = !match;
            shrink           = match;
          end
          default: begin
            cell_ctl.wr_last = 1'b1;
          end
        endcase
      end
      bale_pkg::ST_FIN: begin
        cell_ctl.wr_end = out_load && app_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (grow) begin
      count_d = count_q + LW'(1);
    end else if (shrink) begin
      count_d = count_q - LW'(1);
    end else if ((state_q == bale_pkg::ST_FIN) && out_load) begin
      if (app_q) begin
        count_d = count_q + LW'(1);
      end else if (cmd_q == bale_pkg::CMD_CLEAR) begin
        count_d = '0;
      end
    end
  end

  assign len_ext = CMPW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bale_pkg::ST_IDLE;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (accept) begin
        found_q <= 1'b0;
      end else if ((state_q == bale_pkg::ST_SCAN) && (cmd_q == bale_pkg::CMD_FIND)
                   && !found_q && match) begin
        found_q <= 1'b1;
      end
      if ((state_q == bale_pkg::ST_FIN) && out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_in;
      pos_q    <= position_i;
      word_q   <= word_i;
      status_q <= status_in;
      app_q    <= app_in;
      cnt_q    <= count_q;
      i_q      <= '0;
      rd_q     <= '0;
      fpos_q   <= '0;
    end else if (state_q == bale_pkg::ST_SCAN) begin
      i_q <= i_q + LW'(1);
      if ((cmd_q == bale_pkg::CMD_GET) && hit) begin
        rd_q <= tap;
      end
      if ((cmd_q == bale_pkg::CMD_FIND) && !found_q && match) begin
        fpos_q <= i_ext[bale_pkg::FPOS_W-1:0];
      end
    end
    if ((state_q == bale_pkg::ST_FIN) && out_load) begin
      out_status_q <= status_q;
      out_rd_q     <= rd_q;
      out_found_q  <= found_q;
      out_fpos_q   <= fpos_q;
      out_len_q    <= len_ext[bale_pkg::POS_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign read_word_o      = out_rd_q;
  assign found_o          = out_found_q;
  assign found_position_o = out_fpos_q;
  assign list_length_o    = out_len_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_L)
    else $error("list length beyond capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bale_pkg::ST_SCAN) |-> (i_q < cnt_q))
    else $error("scan ran past the entries it started with");

  a_idle_keeps_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bale_pkg::ST_IDLE) |=> $stable(count_q))
    else $error("list length changed on acceptance");

  a_found_only_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && (state_q != bale_pkg::ST_IDLE)) |-> (cmd_q == bale_pkg::CMD_FIND))
    else $error("match flag set by a command other than find");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_in == bale_pkg::CMD_APPEND) && (count_q != CAP_L))
    |=> (status_q == bale_pkg::STS_OK) && app_q)
    else $error("append rejected below capacity");
`endif

endmodule

### tb/tb_top.sv
// self-checking testbench for the bounded array list engine
module tb_top;

  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 20000;

  typedef struct {
    bale_pkg::status_e status;
    logic [31:0]       read_word;
    logic              found;
    logic [7:0]        found_pos;
    logic [8:0]        length;
  } list_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         command_i;
  logic [8:0]         position_i;
  logic signed [31:0] word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic signed [31:0] read_word_o;
  logic               found_o;
  logic [7:0]         found_position_o;
  logic [8:0]         list_length_o;

  // shadow copy of the list
  logic [31:0]  list_mem [LIST_DEPTH];
  int unsigned  list_len = 0;
  list_result_t pending_results [$];
  logic [31:0]  word_pool [8];
  int unsigned  fail_count = 0;
  bit           send_idle = 1'b1;
  bit           stall_idle = 1'b1;

  bounded_array_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .position_i      (position_i),
    .word_i          (word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .read_word_o     (read_word_o),
    .found_o         (found_o),
    .found_position_o(found_position_o),
    .list_length_o   (list_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic predict_list(input bale_pkg::cmd_e c, input logic [8:0] p,
                              input logic [31:0] w, output list_result_t r);
    int unsigned keep;
    r = '{status: bale_pkg::STS_OK, read_word: '0, found: 1'b0, found_pos: '0,
          length: '0};
    keep = 0;
    case (c)
      bale_pkg::CMD_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = bale_pkg::STS_FULL;
        end else begin
          list_mem[list_len] = w;
          list_len++;
        end
      end
      bale_pkg::CMD_INSERT: begin
        // position is checked before fullness
        if (p > list_len) begin
          r.status = bale_pkg::STS_BAD_INDEX;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = bale_pkg::STS_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i - 1];
          list_mem[p] = w;
          list_len++;
        end
      end
      bale_pkg::CMD_SET: begin
        if (p >= list_len) r.status = bale_pkg::STS_BAD_INDEX;
        else list_mem[p] = w;
      end
      bale_pkg::CMD_GET: begin
        if (p >= list_len) r.status = bale_pkg::STS_BAD_INDEX;
        else r.read_word = list_mem[p];
      end
      bale_pkg::CMD_FIND: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == w) begin
            r.found = 1'b1;
            r.found_pos = 8'(i);
            break;
          end
        end
      end
      bale_pkg::CMD_REMOVE_AT: begin
        if (p >= list_len) begin
          r.status = bale_pkg::STS_BAD_INDEX;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      bale_pkg::CMD_REMOVE_VALUE: begin
        // stable compaction
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] != w) begin
            list_mem[keep] = list_mem[i];
            keep++;
          end
        end
        list_len = keep;
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.length = list_len[8:0];
  endtask

  task automatic send_cmd(input bale_pkg::cmd_e c, input logic [8:0] p,
                          input logic [31:0] w);
    list_result_t r;
    int unsigned gap;
    if (send_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      @(posedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
    end
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    command_i <= c;
    position_i <= p;
    word_i <= w;
    // item is taken at the next edge once stall is low
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    predict_list(c, p, w, r);
    pending_results.push_back(r);
  endtask

  task automatic send_random_op(input int unsigned target);
    int unsigned    pick;
    int unsigned    sel;
    bale_pkg::cmd_e c;
    logic [8:0]     p;
    logic [31:0]    w;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      c = bale_pkg::cmd_e'($urandom_range(int'(bale_pkg::CMD_APPEND),
                                          int'(bale_pkg::CMD_CLEAR)));
    end else if (pick < 8) begin
      c = bale_pkg::CMD_CLEAR;
    end else if (pick < 40) begin
      if (list_len <= target) begin
        c = $urandom_range(0, 1) ? bale_pkg::CMD_APPEND : bale_pkg::CMD_INSERT;
      end else begin
        c = $urandom_range(0, 2) ? bale_pkg::CMD_REMOVE_AT : bale_pkg::CMD_REMOVE_VALUE;
      end
    end else begin
      c = bale_pkg::cmd_e'($urandom_range(int'(bale_pkg::CMD_SET),
                                          int'(bale_pkg::CMD_REMOVE_VALUE)));
    end
    sel = $urandom_range(0, 19);
    if (pick < 6 || sel == 0) p = 9'($urandom_range(0, LIST_DEPTH));
    else if (sel == 1) p = 9'(list_len);
    else if (c == bale_pkg::CMD_INSERT) p = 9'($urandom_range(0, list_len));
    else p = (list_len == 0) ? '0 : 9'($urandom_range(0, list_len - 1));
    // pooled words make find and remove_value hit often
    if ($urandom_range(0, 3) != 0) w = word_pool[$urandom_range(0, 7)];
    else w = $urandom;
    send_cmd(c, p, w);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic test_basic_ops();
    send_cmd(bale_pkg::CMD_GET, 9'd0, 32'd0);
    send_cmd(bale_pkg::CMD_INSERT, 9'd1, 32'h0000_0042);
    send_cmd(bale_pkg::CMD_FIND, 9'd0, 32'hffff_ffff);
    send_cmd(bale_pkg::CMD_REMOVE_VALUE, 9'd0, 32'd0);
    send_cmd(bale_pkg::CMD_REMOVE_AT, 9'd0, 32'd0);
    send_cmd(bale_pkg::CMD_APPEND, 9'd0, 32'h7fff_ffff);
    send_cmd(bale_pkg::CMD_APPEND, 9'd0, 32'h8000_0000);
    send_cmd(bale_pkg::CMD_INSERT, 9'd0, 32'hffff_ffff);
    send_cmd(bale_pkg::CMD_INSERT, 9'd3, 32'h0000_0000);
    send_cmd(bale_pkg::CMD_INSERT, 9'd2, 32'h0000_0001);
    send_cmd(bale_pkg::CMD_SET, 9'd4, 32'ha5a5_5a5a);
    send_cmd(bale_pkg::CMD_SET, 9'd5, 32'h1111_1111);
    send_cmd(bale_pkg::CMD_GET, 9'd0, 32'hffff_ffff);
    send_cmd(bale_pkg::CMD_GET, 9'd4, 32'd0);
    send_cmd(bale_pkg::CMD_GET, 9'd5, 32'd0);
    send_cmd(bale_pkg::CMD_FIND, 9'd0, 32'h8000_0000);
    send_cmd(bale_pkg::CMD_FIND, 9'd0, 32'h1234_5678);
    send_cmd(bale_pkg::CMD_REMOVE_AT, 9'd0, 32'd0);
    send_cmd(bale_pkg::CMD_APPEND, 9'd0, 32'h0000_0001);
    send_cmd(bale_pkg::CMD_REMOVE_VALUE, 9'd0, 32'h0000_0001);
    send_cmd(bale_pkg::CMD_REMOVE_AT, 9'd256, 32'd0);
    send_cmd(bale_pkg::CMD_SET, 9'd256, 32'hdead_beef);
    send_cmd(bale_pkg::CMD_CLEAR, 9'd0, 32'd0);
    send_cmd(bale_pkg::CMD_GET, 9'd0, 32'd0);
    send_cmd(bale_pkg::CMD_APPEND, 9'd511, 32'hffff_ffff);
  endtask

  task automatic test_full_list();
    send_cmd(bale_pkg::CMD_CLEAR, 9'd0, 32'd0);
    while (list_len < LIST_DEPTH) begin
      send_cmd(bale_pkg::CMD_APPEND, 9'($urandom_range(0, LIST_DEPTH)),
               $urandom_range(0, 1) ? word_pool[$urandom_range(0, 3)] : $urandom);
    end
    send_cmd(bale_pkg::CMD_APPEND, 9'd0, 32'h0bad_0bad);
    send_cmd(bale_pkg::CMD_INSERT, 9'd256, 32'h0bad_0bad);
    send_cmd(bale_pkg::CMD_INSERT, 9'd0, 32'h0bad_0bad);
    send_cmd(bale_pkg::CMD_GET, 9'd255, 32'd0);
    send_cmd(bale_pkg::CMD_GET, 9'd256, 32'd0);
    send_cmd(bale_pkg::CMD_SET, 9'd255, 32'h1357_2468);
    send_cmd(bale_pkg::CMD_FIND, 9'd0, 32'h1357_2468);
    send_cmd(bale_pkg::CMD_REMOVE_AT, 9'd0, 32'd0);
    send_cmd(bale_pkg::CMD_INSERT, 9'd0, 32'h8000_0000);
    send_cmd(bale_pkg::CMD_REMOVE_AT, 9'd255, 32'd0);
    send_cmd(bale_pkg::CMD_APPEND, 9'd0, 32'h7fff_ffff);
    send_cmd(bale_pkg::CMD_FIND, 9'd0, word_pool[1]);
    send_cmd(bale_pkg::CMD_REMOVE_VALUE, 9'd0, word_pool[0]);
    send_cmd(bale_pkg::CMD_GET, 9'd0, 32'd0);
    send_cmd(bale_pkg::CMD_CLEAR, 9'd0, 32'd0);
  endtask

  task automatic test_random_mix(input int unsigned n_items);
    int unsigned target;
    target = 8;
    for (int unsigned k = 0; k < n_items; k++) begin
      // most segments stay short, a few grow long
      if (k % 40 == 0) begin
        target = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
      end
      send_random_op(target);
    end
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    send_idle = 1'b0;
    stall_idle = 1'b0;
    for (int unsigned k = 0; k < n_items; k++) send_random_op(16);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // receiver stall bursts
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_idle && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : result_checker
    list_result_t exp_r;
    forever begin
      @(negedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d length %0d",
                   $time, status_o, list_length_o);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("status", exp_r.status, status_o);
          check_field("read_word", exp_r.read_word, read_word_o);
          check_field("found", exp_r.found, found_o);
          check_field("found_position", exp_r.found_pos, found_position_o);
          check_field("list_length", exp_r.length, list_length_o);
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    command_i <= bale_pkg::CMD_APPEND;
    position_i <= '0;
    word_i <= '0;
    foreach (word_pool[i]) word_pool[i] = $urandom;
    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7fff_ffff;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_full_list();
    test_random_mix(100);
    test_back_to_back(60);

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
